// File: hdl/akvot_pkg.sv
// Shared types, codes and helpers of the address-keyed value override table.
package akvot_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_SERVICE = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    STAT_UPDATED   = 4'd0,
    STAT_ADDED     = 4'd1,
    STAT_FULL      = 4'd2,
    STAT_BAD_SIZE  = 4'd3,
    STAT_REMOVED   = 4'd4,
    STAT_ABSENT    = 4'd5,
    STAT_CLEARED   = 4'd6,
    STAT_WRITE     = 4'd7,
    STAT_NO_WRITE  = 4'd8,
    STAT_UNMATCHED = 4'd9
  } status_t;

  localparam logic [2:0] VT_I64 = 3'd3;
  localparam logic [2:0] VT_F32 = 3'd4;
  localparam logic [2:0] VT_F64 = 3'd5;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    logic [63:0] last;
    logic [3:0]  size;
    logic        mode;
    logic [2:0]  vtype;
  } entry_t;

  typedef struct packed {
    logic        done;
    logic        wr;
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic [63:0] last_new;
  } scale_res_t;

  function automatic logic [63:0] byte_mask(logic [3:0] n);
    logic [63:0] m;
    if (n >= 4'd8) begin
      m = '1;
    end else begin
      m = (64'd1 << {n[2:0], 3'b000}) - 64'd1;
    end
    return m;
  endfunction

endpackage

// File: hdl/akvot_mem.sv
// Entry memory with one read and one write port and reset-cleared value valid bits.
module akvot_mem (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      rd_en,
  input  logic [akvot_pkg::IDX_W-1:0] rd_addr,
  output akvot_pkg::entry_t         rd_data,
  input  logic                      wr_en,
  input  logic [akvot_pkg::IDX_W-1:0] wr_addr,
  input  akvot_pkg::entry_t         wr_data
);
  import akvot_pkg::*;

  entry_t                 mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid;
  entry_t                 rd_q;
  logic                   rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // A value never written since reset reads as zero.
  always_comb begin
    rd_data = rd_q;
    if (!rd_valid) begin
      rd_data.value = '0;
    end
  end

endmodule

// File: hdl/akvot_mult.sv
// Radix-2 shift-and-add multiplier, 64 by 64 bits to a 128-bit product.
module akvot_mult (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [127:0]  p
);
  import akvot_pkg::*;

  logic [63:0] hi;
  logic [63:0] lo;
  logic [63:0] a_q;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_q} : 65'd0);
  assign p   = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == 6'd63);
      if (start) begin
        busy <= 1'b1;
        hi   <= '0;
        lo   <= b;
        a_q  <= a;
        cnt  <= '0;
      end else if (busy) begin
        hi  <= sum[64:1];
        lo  <= {sum[0], lo[63:1]};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: hdl/akvot_scale.sv
// Scale unit: wrapping integer and IEEE f32/f64 multiply of the observed value by the factor.
module akvot_scale (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2:0]             vtype,
  input  logic [63:0]            seen,
  input  logic [63:0]            factor,
  input  logic [63:0]            last,
  output akvot_pkg::scale_res_t  res
);
  import akvot_pkg::*;

  typedef enum logic [6:0] {
    SC_IDLE   = 7'b0000001,
    SC_MUL    = 7'b0000010,
    SC_NORM   = 7'b0000100,
    SC_DENORM = 7'b0001000,
    SC_ROUND  = 7'b0010000,
    SC_PACK   = 7'b0100000,
    SC_FIN    = 7'b1000000
  } sc_state_t;

  typedef struct packed {
    logic        sign;
    logic [10:0] exp;
    logic [51:0] frac;
  } fp_t;

  function automatic fp_t funpack(logic d, logic [63:0] x);
    fp_t f;
    if (d) begin
      f = {x[63], x[62:52], x[51:0]};
    end else begin
      f = {x[31], {3'b000, x[30:23]}, {x[22:0], 29'd0}};
    end
    return f;
  endfunction

  function automatic logic [63:0] fpack(logic d, logic s, logic [10:0] e, logic [51:0] f);
    logic [63:0] r;
    if (d) begin
      r = {s, e, f};
    end else begin
      r = {32'd0, s, e[7:0], f[51:29]};
    end
    return r;
  endfunction

  sc_state_t          state;
  logic               dbl;
  logic               is_flt;
  logic [63:0]        mask_q;
  logic [3:0]         nbytes_q;
  logic [63:0]        last_q;
  logic signed [12:0] er;
  logic [105:0]       prod;
  logic               sticky;
  logic               sign_q;
  logic [53:0]        kept_r;
  logic [63:0]        fin_data;

  logic               done_q;
  logic               wr_q;
  logic [63:0]        data_q;
  logic [3:0]         nb_q;
  logic [63:0]        last_new_q;

  // Decode of a new request
  logic               d_in;
  fp_t                fa, fc, fl;
  logic [10:0]        maxe_in;
  logic               nan_a, nan_c, nan_l, inf_a, inf_c, zero_a, zero_c, zero_l;
  logic [63:0]        int_mask;
  logic [3:0]         int_bytes;
  logic signed [12:0] bias_in, ea, ec;
  logic               int_eq, flt_eq, done_next;
  logic               mul_start;
  logic [63:0]        mul_a, mul_b;
  logic               mul_done;
  logic [127:0]       mul_p;

  // Working constants of the held format
  logic signed [12:0] bias_q, emin_q;
  logic [10:0]        maxe_q;

  // Rounding and packing
  logic [52:0]        kept;
  logic               guard, st_all, inc;
  logic               carry, lead, ovf;
  logic [53:0]        mant;
  logic signed [12:0] e_fin, fld;
  logic [63:0]        pack_res;

  assign d_in      = (vtype == VT_F64);
  assign fa        = funpack(d_in, seen);
  assign fc        = funpack(d_in, factor);
  assign fl        = funpack(d_in, last);
  assign maxe_in   = d_in ? 11'h7FF : 11'h0FF;
  assign nan_a     = (fa.exp == maxe_in) && (fa.frac != '0);
  assign nan_c     = (fc.exp == maxe_in) && (fc.frac != '0);
  assign nan_l     = (fl.exp == maxe_in) && (fl.frac != '0);
  assign inf_a     = (fa.exp == maxe_in) && (fa.frac == '0);
  assign inf_c     = (fc.exp == maxe_in) && (fc.frac == '0);
  assign zero_a    = (fa.exp == '0) && (fa.frac == '0);
  assign zero_c    = (fc.exp == '0) && (fc.frac == '0);
  assign zero_l    = (fl.exp == '0) && (fl.frac == '0);
  assign int_bytes = 4'd1 << vtype[1:0];
  assign int_mask  = byte_mask(int_bytes);
  assign bias_in   = d_in ? 13'sd1023 : 13'sd127;
  assign ea = signed'({2'b00, (fa.exp == '0) ? 11'd1 : fa.exp}) - bias_in;
  assign ec = signed'({2'b00, (fc.exp == '0) ? 11'd1 : fc.exp}) - bias_in;

  // A request whose value equals the last, or whose type is not scalable, finishes in the cycle after it is taken.
  assign int_eq    = ((seen & int_mask) == (last & int_mask));
  assign flt_eq    = !nan_a && !nan_l && ((fa == fl) || (zero_a && zero_l));
  assign done_next = (state == SC_FIN) ||
                     ((state == SC_IDLE) && start &&
                      ((vtype <= VT_I64) ? int_eq :
                       (vtype == VT_F32 || vtype == VT_F64) ? flt_eq : 1'b1));

  assign bias_q = dbl ? 13'sd1023 : 13'sd127;
  assign emin_q = dbl ? -13'sd1022 : -13'sd126;
  assign maxe_q = dbl ? 11'h7FF : 11'h0FF;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = seen & int_mask;
    mul_b     = factor & int_mask;
    if (start && state == SC_IDLE) begin
      if (vtype <= VT_I64) begin
        mul_start = ((seen & int_mask) != (last & int_mask));
      end else if (vtype == VT_F32 || vtype == VT_F64) begin
        mul_a = {11'd0, fa.exp != '0, fa.frac};
        mul_b = {11'd0, fc.exp != '0, fc.frac};
        mul_start = !(!nan_a && !nan_l && ((fa == fl) || (zero_a && zero_l))) &&
                    !nan_a && !nan_c && !inf_a && !inf_c && !zero_a && !zero_c;
      end
    end
  end

  akvot_mult u_mult (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  always_comb begin
    kept   = dbl ? prod[105:53] : {29'd0, prod[105:82]};
    guard  = dbl ? prod[52] : prod[81];
    st_all = sticky | (dbl ? (|prod[51:0]) : (|prod[80:0]));
    inc    = guard & (st_all | kept[0]);
    carry  = dbl ? kept_r[53] : kept_r[24];
    mant   = carry ? (kept_r >> 1) : kept_r;
    e_fin  = carry ? (er + 13'sd1) : er;
    lead   = dbl ? mant[52] : mant[23];
    fld    = e_fin + bias_q;
    ovf    = lead && (fld >= signed'({2'b00, maxe_q}));
    if (ovf) begin
      pack_res = fpack(dbl, sign_q, 11'h7FF, 52'd0);
    end else begin
      pack_res = fpack(dbl, sign_q, lead ? fld[10:0] : 11'd0,
                       dbl ? mant[51:0] : {mant[22:0], 29'd0});
    end
  end

  assign res.done     = done_q;
  assign res.wr       = wr_q;
  assign res.data     = data_q;
  assign res.nbytes   = nb_q;
  assign res.last_new = last_new_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SC_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= done_next;
      case (state)
        SC_IDLE: begin
          if (start) begin
            dbl    <= d_in;
            last_q <= last;
            sticky <= 1'b0;
            sign_q <= fa.sign ^ fc.sign;
            er     <= ea + ec + 13'sd1;
            if (vtype <= VT_I64) begin
              is_flt   <= 1'b0;
              mask_q   <= int_mask;
              nbytes_q <= int_bytes;
              if ((seen & int_mask) == (last & int_mask)) begin
                wr_q <= 1'b0;
              end else begin
                state <= SC_MUL;
              end
            end else if (vtype == VT_F32 || vtype == VT_F64) begin
              is_flt   <= 1'b1;
              mask_q   <= d_in ? '1 : 64'h0000_0000_FFFF_FFFF;
              nbytes_q <= d_in ? 4'd8 : 4'd4;
              if (!nan_a && !nan_l && ((fa == fl) || (zero_a && zero_l))) begin
                wr_q <= 1'b0;
              end else if (nan_a) begin
                fin_data <= fpack(d_in, fa.sign, fa.exp, fa.frac | (52'd1 << 51));
                state    <= SC_FIN;
              end else if (nan_c) begin
                fin_data <= fpack(d_in, fc.sign, fc.exp, fc.frac | (52'd1 << 51));
                state    <= SC_FIN;
              end else if ((inf_a && zero_c) || (zero_a && inf_c)) begin
                fin_data <= fpack(d_in, 1'b1, 11'h7FF, 52'd1 << 51);
                state    <= SC_FIN;
              end else if (inf_a || inf_c) begin
                fin_data <= fpack(d_in, fa.sign ^ fc.sign, 11'h7FF, 52'd0);
                state    <= SC_FIN;
              end else if (zero_a || zero_c) begin
                fin_data <= fpack(d_in, fa.sign ^ fc.sign, 11'd0, 52'd0);
                state    <= SC_FIN;
              end else begin
                state <= SC_MUL;
              end
            end else begin
              wr_q <= 1'b0;
            end
          end
        end
        SC_MUL: begin
          if (mul_done) begin
            if (is_flt) begin
              prod  <= mul_p[105:0];
              state <= SC_NORM;
            end else begin
              fin_data <= mul_p[63:0];
              state    <= SC_FIN;
            end
          end
        end
        SC_NORM: begin
          // Bring the leading one to the top bit, one place a cycle.
          if (!prod[105]) begin
            prod <= {prod[104:0], 1'b0};
            er   <= er - 13'sd1;
          end else if (er < emin_q) begin
            if ((emin_q - er) > 13'sd110) begin
              prod   <= '0;
              sticky <= 1'b1;
              er     <= emin_q;
              state  <= SC_ROUND;
            end else begin
              state <= SC_DENORM;
            end
          end else begin
            state <= SC_ROUND;
          end
        end
        SC_DENORM: begin
          if (er < emin_q) begin
            sticky <= sticky | prod[0];
            prod   <= {1'b0, prod[105:1]};
            er     <= er + 13'sd1;
          end else begin
            state <= SC_ROUND;
          end
        end
        SC_ROUND: begin
          kept_r <= {1'b0, kept} + {53'd0, inc};
          state  <= SC_PACK;
        end
        SC_PACK: begin
          fin_data <= pack_res;
          state    <= SC_FIN;
        end
        SC_FIN: begin
          wr_q       <= 1'b1;
          data_q     <= fin_data & mask_q;
          nb_q       <= nbytes_q;
          last_new_q <= (last_q & ~mask_q) | (fin_data & mask_q);
          state      <= SC_IDLE;
        end
        default: begin
          state <= SC_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/address_keyed_value_override_table_top.sv
// Top level of the address-keyed value override table: sequencer, output register, checks.
//
// The block holds up to 64 address-keyed entries in one entry memory and handles one
// transaction at a time. Every command but clear and a rejected size walks the live
// entries in order, one memory read a cycle; adding a new key or removing a non-last
// entry adds an extra read and a write in S_MOVE. A scale service runs the shift-and-add
// multiplier and, for floating-point types, a bit-a-cycle normalisation and rounding
// tail; a subnormal result adds the SC_DENORM shift, while equal values and special
// operands skip the multiplier. Clear and a rejected size go straight to S_DONE with no
// search. The next transaction is taken once the result sits in the output register,
// even while that result waits.
module address_keyed_value_override_table_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [63:0] target_address,
  input  logic [63:0] new_value,
  input  logic [3:0]  byte_count,
  input  logic        entry_mode,
  input  logic [2:0]  value_type,
  input  logic [63:0] observed_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic        write_enable,
  output logic [63:0] write_address,
  output logic [63:0] write_data,
  output logic [3:0]  write_bytes,
  output logic [6:0]  live_entries
);
  import akvot_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_MOVE   = 5'b00100,
    S_SCALE  = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t           state;
  cmd_t             cmd_q;
  logic [63:0]      addr_q;
  logic [63:0]      nval_q;
  logic [3:0]       cnt_q;
  logic             mode_q;
  logic [2:0]       type_q;
  logic [63:0]      seen_q;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] idx;
  logic [IDX_W-1:0] ridx;
  logic             pend;
  status_t          res_status;
  logic             res_we;
  logic [63:0]      res_wdata;
  logic [3:0]       res_wbytes;

  logic             rd_en, wr_en, sc_start, search_issue, hit_now, miss_now, not_top;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  entry_t           rd_data, wr_data, add_entry;
  logic [63:0]      add_mask;
  scale_res_t       sc_res;

  assign in_stall  = (state != S_IDLE);
  assign hit_now   = pend && (rd_data.key == addr_q);
  assign miss_now  = !pend && (idx >= total);
  assign not_top   = (CNT_W'(ridx) < (total - CNT_W'(1)));
  assign add_mask  = byte_mask(cnt_q);

  always_comb begin
    add_entry       = '0;
    add_entry.key   = addr_q;
    add_entry.value = (rd_data.value & ~add_mask) | (nval_q & add_mask);
    add_entry.last  = '0;
    add_entry.size  = cnt_q;
    add_entry.mode  = mode_q;
    add_entry.vtype = type_q;
  end

  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = idx[IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = ridx;
    wr_data      = rd_data;
    sc_start     = 1'b0;
    search_issue = 1'b0;
    case (state)
      S_SEARCH: begin
        if (hit_now) begin
          case (cmd_q)
            CMD_ADD: begin
              wr_en   = 1'b1;
              wr_data = add_entry;
            end
            CMD_REMOVE: begin
              // Fetch the last entry to fill the freed slot.
              rd_en   = not_top;
              rd_addr = IDX_W'(total - CNT_W'(1));
            end
            default: begin
              sc_start = rd_data.mode;
            end
          endcase
        end else if (idx < total) begin
          rd_en        = 1'b1;
          search_issue = 1'b1;
        end else if (miss_now && cmd_q == CMD_ADD && total < CNT_W'(TABLE_DEPTH)) begin
          rd_en   = 1'b1;
          rd_addr = total[IDX_W-1:0];
        end
      end
      S_MOVE: begin
        wr_en = 1'b1;
        if (cmd_q == CMD_ADD) begin
          wr_addr = total[IDX_W-1:0];
          wr_data = add_entry;
        end
      end
      S_SCALE: begin
        if (sc_res.done && sc_res.wr) begin
          wr_en        = 1'b1;
          wr_data.last = sc_res.last_new;
        end
      end
      default: begin
      end
    endcase
  end

  akvot_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  akvot_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (sc_start),
    .vtype  (rd_data.vtype),
    .seen   (seen_q),
    .factor (rd_data.value),
    .last   (rd_data.last),
    .res    (sc_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q      <= cmd_t'(command);
            addr_q     <= target_address;
            nval_q     <= new_value;
            cnt_q      <= byte_count;
            mode_q     <= entry_mode;
            type_q     <= value_type;
            seen_q     <= observed_word;
            idx        <= '0;
            pend       <= 1'b0;
            res_we     <= 1'b0;
            res_wdata  <= '0;
            res_wbytes <= '0;
            case (cmd_t'(command))
              CMD_ADD: begin
                if (byte_count > 4'd8) begin
                  res_status <= STAT_BAD_SIZE;
                  state      <= S_DONE;
                end else begin
                  state <= S_SEARCH;
                end
              end
              CMD_CLEAR: begin
                total      <= '0;
                res_status <= STAT_CLEARED;
                state      <= S_DONE;
              end
              default: begin
                state <= S_SEARCH;
              end
            endcase
          end
        end
        S_SEARCH: begin
          pend <= search_issue;
          if (search_issue) begin
            idx  <= idx + CNT_W'(1);
            ridx <= idx[IDX_W-1:0];
          end
          if (hit_now) begin
            case (cmd_q)
              CMD_ADD: begin
                res_status <= STAT_UPDATED;
                state      <= S_DONE;
              end
              CMD_REMOVE: begin
                if (not_top) begin
                  state <= S_MOVE;
                end else begin
                  total      <= total - CNT_W'(1);
                  res_status <= STAT_REMOVED;
                  state      <= S_DONE;
                end
              end
              default: begin
                if (!rd_data.mode) begin
                  res_status <= STAT_WRITE;
                  res_we     <= 1'b1;
                  res_wdata  <= rd_data.value & byte_mask(rd_data.size);
                  res_wbytes <= rd_data.size;
                  state      <= S_DONE;
                end else begin
                  state <= S_SCALE;
                end
              end
            endcase
          end else if (miss_now) begin
            case (cmd_q)
              CMD_ADD: begin
                if (total >= CNT_W'(TABLE_DEPTH)) begin
                  res_status <= STAT_FULL;
                  state      <= S_DONE;
                end else begin
                  state <= S_MOVE;
                end
              end
              CMD_REMOVE: begin
                res_status <= STAT_ABSENT;
                state      <= S_DONE;
              end
              default: begin
                res_status <= STAT_UNMATCHED;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_MOVE: begin
          if (cmd_q == CMD_ADD) begin
            total      <= total + CNT_W'(1);
            res_status <= STAT_ADDED;
          end else begin
            total      <= total - CNT_W'(1);
            res_status <= STAT_REMOVED;
          end
          state <= S_DONE;
        end
        S_SCALE: begin
          if (sc_res.done) begin
            if (sc_res.wr) begin
              res_status <= STAT_WRITE;
              res_we     <= 1'b1;
              res_wdata  <= sc_res.data;
              res_wbytes <= sc_res.nbytes;
            end else begin
              res_status <= STAT_NO_WRITE;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            status        <= res_status;
            write_enable  <= res_we;
            write_address <= res_we ? addr_q : 64'd0;
            write_data    <= res_wdata;
            write_bytes   <= res_wbytes;
            live_entries  <= 7'(total);
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_total_bounded: assert property (@(posedge clk) disable iff (rst)
    total <= CNT_W'(TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  a_write_when_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_SEARCH || state == S_MOVE || state == S_SCALE))
    else $error("entry memory written outside a transaction");

  a_scale_owned: assert property (@(posedge clk) disable iff (rst)
    sc_res.done |-> (state == S_SCALE))
    else $error("scale result arrived while not waiting for it");

  a_search_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (idx <= total))
    else $error("search index ran past the live entries");

endmodule
